### hdl/acl_pkg.sv
// ----------------------------------------------------------------------------
// APDU command length parser package
// Shared widths, constants, register indexes and the frame and descriptor
// types of the command frame length parser.
// ----------------------------------------------------------------------------
package acl_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned LC_W       = 16;
  localparam int unsigned OFFSET_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned HDR_BYTES  = 4;
  localparam int unsigned LEN_BYTES  = 3;

  localparam logic [COUNT_W-1:0]  COUNT_MAX          = 17'h1FFFF;
  localparam logic [COUNT_W-1:0]  HEADER_COUNT       = 17'd4;
  localparam logic [COUNT_W-1:0]  SHORT_LE_COUNT     = 17'd5;
  localparam logic [COUNT_W-1:0]  EXT_LE_COUNT       = 17'd7;
  localparam logic [COUNT_W-1:0]  EXT_BODY_EXTRA     = 17'd7;
  localparam logic [COUNT_W-1:0]  EXT_LE_EXTRA       = 17'd9;
  localparam logic [COUNT_W-1:0]  SHORT_BODY_EXTRA   = 17'd5;
  localparam logic [COUNT_W-1:0]  SHORT_LE_EXTRA     = 17'd6;
  localparam logic [LEN_W-1:0]    SHORT_LE_DEFAULT   = 17'h00100;
  localparam logic [LEN_W-1:0]    FRAME_OVERHEAD     = 17'd7;
  localparam logic [OFFSET_W-1:0] OFFSET_NONE        = 3'd0;
  localparam logic [OFFSET_W-1:0] OFFSET_SHORT       = 3'd5;
  localparam logic [OFFSET_W-1:0] OFFSET_EXTENDED    = 3'd7;
  localparam logic [BYTE_W-1:0]   EXT_MARK           = 8'h00;

  localparam logic [LEN_W-1:0]    MAX_COMMAND_RESET  = 17'd1024;
  localparam logic [LEN_W-1:0]    MAX_RESPONSE_RESET = 17'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COMMAND_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESPONSE_LEN = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_WRONG_LEN = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0]                count;
    logic [HDR_BYTES-1:0][BYTE_W-1:0]  hdr;
    logic [LEN_BYTES-1:0][BYTE_W-1:0]  len;
    logic [BYTE_W-1:0]                 prev;
    logic [BYTE_W-1:0]                 cur;
  } acl_frame_t;

  typedef struct packed {
    logic                status;
    logic [BYTE_W-1:0]   class_byte;
    logic [BYTE_W-1:0]   instruction;
    logic [BYTE_W-1:0]   param_one;
    logic [BYTE_W-1:0]   param_two;
    logic [LC_W-1:0]     command_length;
    logic [LEN_W-1:0]    expected_length;
    logic                extended_flag;
    logic [OFFSET_W-1:0] data_start;
  } acl_desc_t;

endpackage

### hdl/acl_if.sv
// ----------------------------------------------------------------------------
// APDU command length parser channels
// Valid/ready channels for command bytes, descriptors and register writes.
// ----------------------------------------------------------------------------
interface acl_byte_if
  import acl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface acl_desc_if
  import acl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                status;
  logic [BYTE_W-1:0]   class_byte;
  logic [BYTE_W-1:0]   instruction;
  logic [BYTE_W-1:0]   param_one;
  logic [BYTE_W-1:0]   param_two;
  logic [LC_W-1:0]     command_length;
  logic [LEN_W-1:0]    expected_length;
  logic                extended_flag;
  logic [OFFSET_W-1:0] data_start;

  modport source (output valid, output status, output class_byte, output instruction,
                  output param_one, output param_two, output command_length,
                  output expected_length, output extended_flag, output data_start,
                  input ready);
  modport sink   (input valid, input status, input class_byte, input instruction,
                  input param_one, input param_two, input command_length,
                  input expected_length, input extended_flag, input data_start,
                  output ready);
endinterface

interface acl_cfg_if
  import acl_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LEN_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/acl_decode.sv
// ----------------------------------------------------------------------------
// APDU frame decoder
// Classifies a captured frame into the header-only, short and extended length
// cases, checks it against the command limit and builds the command descriptor.
// ----------------------------------------------------------------------------
module acl_decode
  import acl_pkg::*;
(
  input  acl_frame_t       frame,
  input  logic [LEN_W-1:0] max_command_len,
  input  logic [LEN_W-1:0] max_response_len,
  output acl_desc_t        desc
);

  logic [COUNT_W-1:0]  n;
  logic [BYTE_W-1:0]   b4;
  logic [LC_W-1:0]     pair56;
  logic [LC_W-1:0]     pair_tail;
  logic [LEN_W-1:0]    limit;
  logic                ok;
  logic [LC_W-1:0]     lc;
  logic [LEN_W-1:0]    le;
  logic                ext;
  logic [OFFSET_W-1:0] ds;

  always_comb begin
    n         = frame.count;
    b4        = frame.len[0];
    pair56    = {frame.len[1], frame.len[2]};
    pair_tail = {frame.prev, frame.cur};
    ok        = 1'b1;
    lc        = '0;
    le        = '0;
    ext       = 1'b0;
    ds        = OFFSET_NONE;

    if (n < HEADER_COUNT) begin
      ok = 1'b0;
    end else if (n == HEADER_COUNT) begin
      ok = 1'b1;
    end else if (b4 == EXT_MARK) begin
      if (n == SHORT_LE_COUNT) begin
        le = SHORT_LE_DEFAULT;
      end else if (n == EXT_LE_COUNT) begin
        le  = (pair56 == '0) ? max_response_len : {1'b0, pair56};
        ext = 1'b1;
      end else if (n > EXT_LE_COUNT) begin
        lc  = pair56;
        ext = 1'b1;
        ds  = OFFSET_EXTENDED;
        if (n == {1'b0, pair56} + EXT_BODY_EXTRA) begin
          le = '0;
        end else if (n == {1'b0, pair56} + EXT_LE_EXTRA) begin
          le = (pair_tail == '0) ? max_response_len : {1'b0, pair_tail};
        end else begin
          ok = 1'b0;
        end
      end else begin
        ok = 1'b0;
      end
    end else begin
      if (n == SHORT_LE_COUNT) begin
        le = {9'b0, b4};
      end else begin
        lc = {8'b0, b4};
        ds = OFFSET_SHORT;
        if (n == {9'b0, b4} + SHORT_BODY_EXTRA) begin
          le = '0;
        end else if (n == {9'b0, b4} + SHORT_LE_EXTRA) begin
          le = (frame.cur == '0) ? SHORT_LE_DEFAULT : {9'b0, frame.cur};
        end else begin
          ok = 1'b0;
        end
      end
    end

    limit = (max_command_len >= FRAME_OVERHEAD) ? max_command_len - FRAME_OVERHEAD : '0;
    if ({1'b0, lc} > limit) begin
      ok = 1'b0;
    end

    desc = '0;
    if (!ok) begin
      desc.status = STATUS_WRONG_LEN;
    end else begin
      desc.status          = STATUS_OK;
      desc.class_byte      = frame.hdr[0];
      desc.instruction     = frame.hdr[1];
      desc.param_one       = frame.hdr[2];
      desc.param_two       = frame.hdr[3];
      desc.command_length  = lc;
      desc.expected_length = le;
      desc.extended_flag   = ext;
      desc.data_start      = ds;
    end
  end

endmodule

### hdl/apdu_command_length_parser.sv
// ----------------------------------------------------------------------------
// APDU command length parser
// Collects command frame bytes and gives one length descriptor per frame.
//
//   Channel  Role   Handshake     Payload
//   cmd      sink   valid/ready   data_byte, last_byte
//   desc     source valid/ready   status, header fields, lengths, flag, offset
//   cfg      sink   valid/ready   index, data (ready is always high)
//
// One byte is taken every cycle while cmd.ready is high. A last byte is captured
// into the frame register, then decoded and loaded into the descriptor register
// once that register is empty or being read. Reset clears the frame state and
// loads the default limits. When the descriptor register is held, the frame
// register fills and cmd.ready drops until it drains.
// ----------------------------------------------------------------------------
module apdu_command_length_parser
  import acl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  acl_byte_if.sink   cmd,
  acl_desc_if.source desc,
  acl_cfg_if.sink    cfg
);

  logic [LEN_W-1:0]                 max_command_len;
  logic [LEN_W-1:0]                 max_response_len;
  logic [COUNT_W-1:0]               byte_count;
  logic [COUNT_W-1:0]               byte_count_next;
  logic [HDR_BYTES-1:0][BYTE_W-1:0] header_bytes;
  logic [HDR_BYTES-1:0][BYTE_W-1:0] header_bytes_next;
  logic [LEN_BYTES-1:0][BYTE_W-1:0] length_bytes;
  logic [LEN_BYTES-1:0][BYTE_W-1:0] length_bytes_next;
  logic [BYTE_W-1:0]                prior_byte;
  acl_frame_t                       frame;
  logic                             frame_valid;
  acl_desc_t                        decoded;
  acl_desc_t                        result;
  logic                             result_valid;
  logic                             cmd_take;
  logic                             frame_adv;

  assign cfg.ready = 1'b1;
  assign frame_adv = frame_valid && (!result_valid || desc.ready);
  assign cmd.ready = !frame_valid || frame_adv;
  assign cmd_take  = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_command_len  <= MAX_COMMAND_RESET;
      max_response_len <= MAX_RESPONSE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MAX_COMMAND_LEN:  max_command_len  <= cfg.data;
        CFG_MAX_RESPONSE_LEN: max_response_len <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    header_bytes_next = header_bytes;
    length_bytes_next = length_bytes;
    if (byte_count < HEADER_COUNT) begin
      header_bytes_next[byte_count[1:0]] = cmd.data_byte;
    end else if (byte_count < EXT_LE_COUNT) begin
      length_bytes_next[byte_count[1:0]] = cmd.data_byte;
    end
    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + 1'b1 : byte_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      header_bytes <= '0;
      length_bytes <= '0;
      prior_byte   <= '0;
    end else if (cmd_take) begin
      if (cmd.last_byte) begin
        byte_count   <= '0;
        header_bytes <= '0;
        length_bytes <= '0;
        prior_byte   <= '0;
      end else begin
        byte_count   <= byte_count_next;
        header_bytes <= header_bytes_next;
        length_bytes <= length_bytes_next;
        prior_byte   <= cmd.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (cmd_take && cmd.last_byte) begin
      frame_valid <= 1'b1;
    end else if (frame_adv) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.last_byte) begin
      frame.count <= byte_count_next;
      frame.hdr   <= header_bytes_next;
      frame.len   <= length_bytes_next;
      frame.prev  <= prior_byte;
      frame.cur   <= cmd.data_byte;
    end
  end

  acl_decode u_decode (
    .frame            (frame),
    .max_command_len  (max_command_len),
    .max_response_len (max_response_len),
    .desc             (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (frame_adv) begin
      result_valid <= 1'b1;
    end else if (desc.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_adv) begin
      result <= decoded;
    end
  end

  assign desc.valid           = result_valid;
  assign desc.status          = result.status;
  assign desc.class_byte      = result.class_byte;
  assign desc.instruction     = result.instruction;
  assign desc.param_one       = result.param_one;
  assign desc.param_two       = result.param_two;
  assign desc.command_length  = result.command_length;
  assign desc.expected_length = result.expected_length;
  assign desc.extended_flag   = result.extended_flag;
  assign desc.data_start      = result.data_start;

  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_adv |=> frame_valid && $stable(frame))
    else $error("Captured frame was lost while the descriptor register was held.");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd_take && cmd.last_byte |=> byte_count == '0 && prior_byte == '0)
    else $error("Frame state was not cleared after the last byte.");

  a_wrong_len_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_WRONG_LEN |->
      result.command_length == '0 && result.expected_length == '0 &&
      result.data_start == OFFSET_NONE && result.extended_flag == 1'b0)
    else $error("Wrong length descriptor carries nonzero fields.");

  a_offset_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.data_start == OFFSET_NONE ||
      result.data_start == OFFSET_SHORT || result.data_start == OFFSET_EXTENDED)
    else $error("Descriptor data offset is not none, short or extended.");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    cmd_take && !cmd.last_byte && byte_count == COUNT_MAX |=> byte_count == COUNT_MAX)
    else $error("Byte count wrapped past its maximum.");

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the APDU command length parser
// Sends command frames byte by byte: short, extended, malformed and noise
// frames, with random bursts and gaps on the byte side and stalls on the
// descriptor side. A built-in frame tracker predicts every descriptor and
// compares it field by field with what the block returns, over several
// limit settings.
// ----------------------------------------------------------------------------
module tb_top;
  import acl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    FR_RUNT, FR_HEADER, FR_SHORT_LE, FR_EXT_LE, FR_SHORT_LC, FR_SHORT_LC_LE,
    FR_EXT_LC, FR_EXT_LC_LE, FR_BROKEN, FR_NOISE
  } frame_kind_e;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  class apdu_frame_tracker;
    acl_desc_t                        due_descriptors[$];
    logic [COUNT_W-1:0]               frame_count;
    logic [HDR_BYTES-1:0][BYTE_W-1:0] hdr;
    logic [LEN_BYTES-1:0][BYTE_W-1:0] lenb;
    logic [BYTE_W-1:0]                prev_byte;
    logic [LEN_W-1:0]                 max_cmd;
    logic [LEN_W-1:0]                 max_rsp;
    int                               fail_count;

    function new();
      frame_count = '0;
      hdr         = '0;
      lenb        = '0;
      prev_byte   = '0;
      max_cmd     = MAX_COMMAND_RESET;
      max_rsp     = MAX_RESPONSE_RESET;
      fail_count  = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
      if (idx == CFG_MAX_COMMAND_LEN) begin
        max_cmd = val;
      end else begin
        max_rsp = val;
      end
    endfunction

    function void take_byte(logic [BYTE_W-1:0] cur, logic last_flag);
      int unsigned         pos;
      int unsigned         n;
      int unsigned         lc;
      int unsigned         le;
      int unsigned         limit;
      logic [BYTE_W-1:0]   prev;
      logic                ok;
      logic                ext;
      logic [OFFSET_W-1:0] start;
      acl_desc_t           d;
      pos = frame_count;
      prev = prev_byte;
      if (pos < HDR_BYTES) begin
        hdr[pos] = cur;
      end else if (pos < HDR_BYTES + LEN_BYTES) begin
        lenb[pos - HDR_BYTES] = cur;
      end
      if (frame_count != COUNT_MAX) frame_count = frame_count + 1'b1;
      prev_byte = cur;
      if (!last_flag) return;

      n = frame_count;
      lc = 0;
      le = 0;
      ext = 1'b0;
      start = OFFSET_NONE;
      ok = 1'b1;
      if (n < HEADER_COUNT) begin
        ok = 1'b0;
      end else if (n == HEADER_COUNT) begin
      end else if (lenb[0] == EXT_MARK) begin
        if (n == SHORT_LE_COUNT) begin
          le = SHORT_LE_DEFAULT;
        end else if (n == EXT_LE_COUNT) begin
          le = {lenb[1], lenb[2]};
          if (le == 0) le = max_rsp;
          ext = 1'b1;
        end else if (n > EXT_LE_COUNT) begin
          lc = {lenb[1], lenb[2]};
          ext = 1'b1;
          start = OFFSET_EXTENDED;
          if (n == lc + EXT_BODY_EXTRA) begin
            le = 0;
          end else if (n == lc + EXT_LE_EXTRA) begin
            le = {prev, cur};
            if (le == 0) le = max_rsp;
          end else begin
            ok = 1'b0;
          end
        end else begin
          ok = 1'b0;
        end
      end else begin
        if (n == SHORT_LE_COUNT) begin
          le = lenb[0];
        end else begin
          lc = lenb[0];
          start = OFFSET_SHORT;
          if (n == lc + SHORT_BODY_EXTRA) begin
            le = 0;
          end else if (n == lc + SHORT_LE_EXTRA) begin
            le = cur;
            if (le == 0) le = SHORT_LE_DEFAULT;
          end else begin
            ok = 1'b0;
          end
        end
      end

      limit = max_cmd;
      limit = (limit >= FRAME_OVERHEAD) ? limit - FRAME_OVERHEAD : 0;
      if (ok && lc > limit) ok = 1'b0;

      d = '0;
      if (!ok) begin
        d.status = STATUS_WRONG_LEN;
      end else begin
        d.status          = STATUS_OK;
        d.class_byte      = hdr[0];
        d.instruction     = hdr[1];
        d.param_one       = hdr[2];
        d.param_two       = hdr[3];
        d.command_length  = lc[LC_W-1:0];
        d.expected_length = le[LEN_W-1:0];
        d.extended_flag   = ext;
        d.data_start      = start;
      end
      due_descriptors.push_back(d);
      frame_count = '0;
      hdr         = '0;
      lenb        = '0;
      prev_byte   = '0;
    endfunction

    function void match_descriptor(acl_desc_t got);
      acl_desc_t want;
      if (due_descriptors.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("Unexpected descriptor %h.", got);
        return;
      end
      want = due_descriptors.pop_front();
      if (got.status !== want.status || got.class_byte !== want.class_byte ||
          got.instruction !== want.instruction || got.param_one !== want.param_one ||
          got.param_two !== want.param_two || got.command_length !== want.command_length ||
          got.expected_length !== want.expected_length ||
          got.extended_flag !== want.extended_flag || got.data_start !== want.data_start) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("Descriptor mismatch (expected/actual): status %0d/%0d cla %h/%h ins %h/%h",
                   want.status, got.status, want.class_byte, got.class_byte,
                   want.instruction, got.instruction);
          $display("  p1 %h/%h p2 %h/%h lc %0d/%0d le %0d/%0d ext %0d/%0d start %0d/%0d",
                   want.param_one, got.param_one, want.param_two, got.param_two,
                   want.command_length, got.command_length,
                   want.expected_length, got.expected_length,
                   want.extended_flag, got.extended_flag, want.data_start, got.data_start);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  acl_byte_if cmd_if();
  acl_desc_if desc_if();
  acl_cfg_if  cfg_if();

  apdu_command_length_parser u_dut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_if),
    .desc (desc_if),
    .cfg  (cfg_if)
  );

  apdu_frame_tracker tracker;
  logic [BYTE_W-1:0] frame_bytes[$];
  int                src_gap_max;
  int                burst_left;
  rx_mode_e          rx_mode;
  logic [15:0]       rx_pattern;
  int                hold_len;
  int unsigned       cycle_count;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && cmd_if.valid && cmd_if.ready) begin
      tracker.take_byte(cmd_if.data_byte, cmd_if.last_byte);
    end
  end

  always @(posedge clk) begin : desc_monitor
    acl_desc_t got;
    if (!rst && desc_if.valid && desc_if.ready) begin
      got.status          = desc_if.status;
      got.class_byte      = desc_if.class_byte;
      got.instruction     = desc_if.instruction;
      got.param_one       = desc_if.param_one;
      got.param_two       = desc_if.param_two;
      got.command_length  = desc_if.command_length;
      got.expected_length = desc_if.expected_length;
      got.extended_flag   = desc_if.extended_flag;
      got.data_start      = desc_if.data_start;
      tracker.match_descriptor(got);
    end
  end

  initial begin
    int n;
    bit hold_used;
    hold_used = 1'b0;
    rx_pattern = 16'($urandom) | 16'h0101;
    desc_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      n = hold_used ? 0 : hold_len;
      if (n > 0) begin
        hold_used = 1'b1;
        desc_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        case (rx_mode)
          RX_ALWAYS: desc_if.ready <= 1'b1;
          RX_RANDOM: desc_if.ready <= ($urandom_range(0, 99) < 65);
          default: begin
            desc_if.ready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
          end
        endcase
      end
    end
  end

  function automatic logic [BYTE_W-1:0] pick_byte(int fill);
    return (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
  endfunction

  function automatic void build_frame(frame_kind_e kind, int lc, bit zero_len, int fill);
    int          n;
    logic [15:0] le;
    if (kind == FR_BROKEN) begin
      case ($urandom_range(0, 2))
        0: begin
          build_frame(frame_kind_e'(FR_HEADER + $urandom_range(0, 6)), lc, zero_len, fill);
          if (frame_bytes.size() > 1) void'(frame_bytes.pop_back());
        end
        1: begin
          build_frame(frame_kind_e'(FR_HEADER + $urandom_range(0, 6)), lc, zero_len, fill);
          frame_bytes.push_back(pick_byte(fill));
        end
        default: begin
          build_frame(FR_HEADER, lc, zero_len, fill);
          frame_bytes.push_back(EXT_MARK);
          frame_bytes.push_back(pick_byte(fill));
        end
      endcase
      return;
    end
    frame_bytes.delete();
    if (kind == FR_RUNT || kind == FR_NOISE) begin
      n = (kind == FR_NOISE) ? $urandom_range(1, 40) : (lc < 1) ? 1 : (lc > 3) ? 3 : lc;
      repeat (n) frame_bytes.push_back(pick_byte(fill));
      return;
    end
    repeat (HDR_BYTES) frame_bytes.push_back(pick_byte(fill));
    le = zero_len ? 16'h0000 : 16'($urandom);
    case (kind)
      FR_SHORT_LE: begin
        frame_bytes.push_back(zero_len ? 8'h00 : BYTE_W'($urandom_range(1, 255)));
      end
      FR_EXT_LE: begin
        frame_bytes.push_back(EXT_MARK);
        frame_bytes.push_back(le[15:8]);
        frame_bytes.push_back(le[7:0]);
      end
      FR_SHORT_LC, FR_SHORT_LC_LE: begin
        n = (lc < 1) ? 1 : (lc > 255) ? 255 : lc;
        frame_bytes.push_back(BYTE_W'(n));
        repeat (n) frame_bytes.push_back(pick_byte(fill));
        if (kind == FR_SHORT_LC_LE) begin
          frame_bytes.push_back(zero_len ? 8'h00 : BYTE_W'($urandom_range(1, 255)));
        end
      end
      FR_EXT_LC, FR_EXT_LC_LE: begin
        frame_bytes.push_back(EXT_MARK);
        frame_bytes.push_back(lc[15:8]);
        frame_bytes.push_back(lc[7:0]);
        repeat (lc) frame_bytes.push_back(pick_byte(fill));
        if (kind == FR_EXT_LC_LE) begin
          frame_bytes.push_back(le[15:8]);
          frame_bytes.push_back(le[7:0]);
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_frame();
    int gap;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = (src_gap_max > 0) ? $urandom_range(0, src_gap_max) : 0;
        if (gap > 0) begin
          @(negedge clk);
          cmd_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      @(negedge clk);
      cmd_if.valid     <= 1'b1;
      cmd_if.data_byte <= frame_bytes[i];
      cmd_if.last_byte <= (i == frame_bytes.size() - 1);
      do @(posedge clk); while (!cmd_if.ready);
    end
  endtask

  task automatic run_random(int budget);
    int          sent;
    int          pick;
    int          lc;
    frame_kind_e kind;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      lc = (pick < 70) ? $urandom_range(0, 12) :
           (pick < 95) ? $urandom_range(13, 64) : $urandom_range(65, 300);
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
        kind = frame_kind_e'(FR_HEADER + $urandom_range(0, 6));
      end else if (pick < 92) begin
        kind = FR_BROKEN;
      end else if (pick < 96) begin
        kind = FR_RUNT;
      end else begin
        kind = FR_NOISE;
      end
      build_frame(kind, lc, ($urandom_range(0, 3) == 0), -1);
      send_frame();
      sent += frame_bytes.size();
    end
  endtask

  task automatic wait_drain();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (tracker.due_descriptors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    tracker.set_limit(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    src_gap_max = 3;
    burst_left = 0;
    rx_mode = RX_RANDOM;
    hold_len = 0;
    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.data_byte = '0;
    cmd_if.last_byte = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_MAX_COMMAND_LEN;
    cfg_if.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    build_frame(FR_RUNT, 2, 1'b0, 8'hFF);
    send_frame();
    build_frame(FR_HEADER, 0, 1'b0, 8'hFF);
    send_frame();
    build_frame(FR_SHORT_LE, 0, 1'b1, 8'h00);
    send_frame();
    build_frame(FR_EXT_LE, 0, 1'b1, 8'h00);
    send_frame();
    build_frame(FR_EXT_LC_LE, 0, 1'b1, -1);
    send_frame();

    src_gap_max = 6;
    run_random(300);
    hold_len = 150;
    src_gap_max = 0;
    repeat (30) begin
      build_frame(FR_HEADER, 0, 1'b0, -1);
      send_frame();
    end
    rx_mode = RX_ALWAYS;
    run_random(120);

    wait_drain();
    write_limit(CFG_MAX_COMMAND_LEN, 17'd7);
    write_limit(CFG_MAX_RESPONSE_LEN, 17'd0);
    src_gap_max = 5;
    rx_mode = RX_PATTERN;
    run_random(220);

    wait_drain();
    write_limit(CFG_MAX_COMMAND_LEN, LEN_W'($urandom_range(0, 6)));
    write_limit(CFG_MAX_RESPONSE_LEN, 17'd1);
    src_gap_max = 2;
    rx_mode = RX_RANDOM;
    run_random(180);

    wait_drain();
    write_limit(CFG_MAX_COMMAND_LEN, 17'd20);
    write_limit(CFG_MAX_RESPONSE_LEN, LEN_W'($urandom_range(0, 131071)));
    src_gap_max = 4;
    rx_mode = RX_PATTERN;
    run_random(200);

    wait_drain();
    write_limit(CFG_MAX_COMMAND_LEN, 17'd65542);
    write_limit(CFG_MAX_RESPONSE_LEN, 17'd65536);
    src_gap_max = 3;
    rx_mode = RX_RANDOM;
    run_random(180);
    src_gap_max = 0;
    build_frame(FR_EXT_LC_LE, 64, 1'b1, -1);
    send_frame();

    wait_drain();
    write_limit(CFG_MAX_COMMAND_LEN, 17'h1FFFF);
    write_limit(CFG_MAX_RESPONSE_LEN, 17'h1FFFF);
    src_gap_max = 4;
    run_random(100);
    src_gap_max = 0;
    build_frame(FR_EXT_LC, 100, 1'b0, -1);
    send_frame();

    wait_drain();
    repeat (20) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.due_descriptors.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
